// ===== rtl/vgm_pkg.sv =====
// Package: shared constants, types and register indexes for the gradient block
`timescale 1ns / 1ps
package vgm_pkg;
	localparam int DefMaxWidth  = 256;
	localparam int DefMaxHeight = 256;
	localparam int SampleW      = 16;
	localparam int CfgIdxW      = 2;
	localparam int CfgDataW     = 9;
	// sum of three squared 17-bit differences, times four
	localparam int SumW         = 36;
	localparam int RootW        = 17;

	localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
	localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
	localparam logic [CfgIdxW-1:0] RegWide   = 2'd2;

	typedef struct packed {
		logic [SampleW-1:0] gradient;
		logic               slice_done;
	} vgm_result_t;
endpackage

// ===== rtl/vgm_stream_if.sv =====
// Interface: valid/ready channel with a generic payload
`timescale 1ns / 1ps
interface vgm_stream_if #(parameter type payload_t = logic [15:0]);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/vgm_sqrt_pipe.sv =====
// Pipelined rounded square root of S/3, one result bit per stage
`timescale 1ns / 1ps
module vgm_sqrt_pipe
	import vgm_pkg::*;
#(
	parameter int TagW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [SumW-1:0] in_four_s,
	input  logic [TagW-1:0] in_tag,
	output logic            out_valid,
	output logic [SampleW-1:0] out_root,
	output logic [TagW-1:0] out_tag
);
	localparam int N = RootW;
	localparam int TW = 2 * RootW + 3;

	logic [N:0]            v_s;
	logic [SumW-1:0]       s_s   [N+1];
	logic [RootW-1:0]      r_s   [N+1];
	logic [TagW-1:0]       tag_s [N+1];

	assign v_s[0]   = in_valid;
	assign s_s[0]   = in_four_s;
	assign r_s[0]   = '0;
	assign tag_s[0] = in_tag;

	// each stage tries one bit, MSB first: keep it if 3(2c-1)^2 <= 4S
	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam int B = N - 1 - i;
		logic [RootW-1:0] c;
		logic [RootW:0]   t;
		logic [TW-1:0]    sq;
		logic             keep;
		always_comb begin
			c    = r_s[i] | (RootW'(1) << B);
			t    = {c, 1'b0} - (RootW+1)'(1);
			sq   = TW'(t) * TW'(t) * TW'(3);
			keep = (sq <= TW'(s_s[i]));
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				s_s[i+1]   <= s_s[i];
				tag_s[i+1] <= tag_s[i];
				r_s[i+1]   <= keep ? c : r_s[i];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_root  = r_s[N][RootW-1] ? '1 : r_s[N][SampleW-1:0];
	assign out_tag   = tag_s[N];
endmodule

// ===== rtl/vgm_front.sv =====
// Front end: raster counters, slice memory, old row buffer, squared differences
`timescale 1ns / 1ps
module vgm_front
	import vgm_pkg::*;
#(
	parameter int MAX_WIDTH  = DefMaxWidth,
	parameter int MAX_HEIGHT = DefMaxHeight
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               restart,
	input  logic [CfgDataW-1:0] width_reg,
	input  logic [CfgDataW-1:0] height_reg,
	input  logic               wide,
	input  logic               in_valid,
	input  logic [SampleW-1:0] in_sample,
	output logic               out_valid,
	output logic [SumW-1:0]    out_four_s,
	output logic               out_done
);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int DW = SampleW + 1;
	localparam int QW = 2 * SampleW;

	logic [XW:0] w_eff, x_q;
	logic [YW:0] h_eff, y_q;
	logic        first_q;

	// clamp geometry to [2, MAX]
	always_comb begin
		if (width_reg < CfgDataW'(2)) w_eff = (XW+1)'(2);
		else if (32'(width_reg) > MAX_WIDTH) w_eff = (XW+1)'(MAX_WIDTH);
		else w_eff = (XW+1)'(width_reg);
		if (height_reg < CfgDataW'(2)) h_eff = (YW+1)'(2);
		else if (32'(height_reg) > MAX_HEIGHT) h_eff = (YW+1)'(MAX_HEIGHT);
		else h_eff = (YW+1)'(height_reg);
	end

	logic [XW:0] x_next;
	logic [YW:0] y_next;
	logic        wrap_x, wrap_y;
	always_comb begin
		wrap_x = (x_q + 1'b1) == w_eff;
		wrap_y = (y_q + 1'b1) == h_eff;
		x_next = wrap_x ? '0 : x_q + 1'b1;
		y_next = wrap_x ? (wrap_y ? '0 : y_q + 1'b1) : y_q;
	end

	// row base address kept incrementally: no multiply
	logic [AW-1:0] base_q;
	logic          take;
	assign take = en && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0; y_q <= '0; base_q <= '0; first_q <= 1'b1;
		end else if (restart) begin
			x_q <= '0; y_q <= '0; base_q <= '0; first_q <= 1'b1;
		end else if (take) begin
			x_q <= x_next;
			y_q <= y_next;
			if (wrap_x) base_q <= wrap_y ? '0 : base_q + AW'(w_eff);
			if (wrap_x && wrap_y) first_q <= 1'b0;
		end
	end

	// stage 1: memory reads issued
	logic [SampleW-1:0] slice_mem [MAX_WIDTH*MAX_HEIGHT];
	logic [SampleW-1:0] row_mem   [MAX_WIDTH];
	logic               v_s1, calc_s1, done_s1;
	logic [SampleW-1:0] cur_s1, center_s1, up_s1;
	logic [AW-1:0]      addr_s1;
	logic [XW-1:0]      xi_s1;
	logic [AW-1:0]      addr_now;
	assign addr_now = base_q + AW'(x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (restart) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	// forward bypass: the previous item's write may hit this read
	logic               wr_s1;
	assign wr_s1 = v_s1 && en;

	always_ff @(posedge clk) begin
		if (take) begin
			cur_s1    <= wide ? in_sample : {8'h00, in_sample[7:0]};
			addr_s1   <= addr_now;
			xi_s1     <= x_q[XW-1:0];
			calc_s1   <= !first_q && x_q != '0 && y_q != '0;
			done_s1   <= wrap_x && wrap_y;
			center_s1 <= (wr_s1 && addr_s1 == addr_now) ? cur_s1 : slice_mem[addr_now];
			up_s1     <= row_mem[x_q[XW-1:0]];
		end
	end

	// stage 1 writes the stores; left neighbor is the previous center
	logic [SampleW-1:0] left_q;
	always_ff @(posedge clk) begin
		if (wr_s1) begin
			slice_mem[addr_s1] <= cur_s1;
			row_mem[xi_s1]     <= center_s1;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) left_q <= '0;
		else if (wr_s1) left_q <= center_s1;
	end

	// the upper read can race a same-column write only if width were 1, never
	// stage 2: differences
	logic signed [DW-1:0] d1_s2, d2_s2, d3_s2;
	logic                 v_s2, done_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1 && calc_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d1_s2   <= $signed({1'b0, left_q}) - $signed({1'b0, center_s1});
			d2_s2   <= $signed({1'b0, up_s1}) - $signed({1'b0, center_s1});
			d3_s2   <= $signed({1'b0, cur_s1}) - $signed({1'b0, center_s1});
			done_s2 <= done_s1;
		end
	end

	// stage 3: squares, operands sign-extended to the product width
	logic [QW-1:0] q1_s3, q2_s3, q3_s3;
	logic          v_s3, done_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q1_s3   <= QW'(d1_s2) * QW'(d1_s2);
			q2_s3   <= QW'(d2_s2) * QW'(d2_s2);
			q3_s3   <= QW'(d3_s2) * QW'(d3_s2);
			done_s3 <= done_s2;
		end
	end

	// stage 4: sum times four
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_four_s <= (SumW'(q1_s3) + SumW'(q2_s3) + SumW'(q3_s3)) << 2;
			out_done   <= done_s3;
		end
	end
endmodule

// ===== rtl/volume_gradient_magnitude.sv =====
// Top level: 3D backward-difference gradient magnitude, streaming
`timescale 1ns / 1ps
// Takes one sample per cycle in raster order (x, then y, then slice) while the
// output is not held, and gives round(sqrt((d1^2+d2^2+d3^2)/3)) for every sample
// at x>=1, y>=1 of each slice after the first. The path from an accepted sample
// to its offered result is 4 front stages, 17 root stages (one result bit each)
// and the output register. A held result stalls the whole pipeline. A write to
// the width, height or wide register restarts the stream at the first slice.
// The slice memory holds MAX_WIDTH*MAX_HEIGHT samples, read and written once
// per cycle while the pipeline advances; its contents count toward a result
// only after being written in the current stream.
module volume_gradient_magnitude
	import vgm_pkg::*;
#(
	parameter int MAX_WIDTH  = DefMaxWidth,
	parameter int MAX_HEIGHT = DefMaxHeight
) (
	input  logic clk,
	input  logic arst_n,
	vgm_stream_if.sink   cfg,
	vgm_stream_if.sink   in_ch,
	vgm_stream_if.source out_ch
);
	logic [CfgDataW-1:0] width_q, height_q;
	logic                wide_q;
	logic [CfgIdxW-1:0]  cfg_idx;
	logic [CfgDataW-1:0] cfg_val;
	logic                cfg_wr, restart;

	assign cfg.ready = 1'b1;
	assign cfg_idx   = cfg.data[CfgIdxW+CfgDataW-1:CfgDataW];
	assign cfg_val   = cfg.data[CfgDataW-1:0];
	assign cfg_wr    = cfg.valid;
	assign restart   = cfg_wr && (cfg_idx inside {RegWidth, RegHeight, RegWide});

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CfgDataW'(256); height_q <= CfgDataW'(256); wide_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				RegWidth:  width_q  <= cfg_val;
				RegHeight: height_q <= cfg_val;
				RegWide:   wide_q   <= cfg_val[0];
				default:   ;
			endcase
		end
	end

	// output register with pipeline enable: advance when output free
	logic        en;
	logic        f_valid, f_done, r_valid;
	logic [SumW-1:0]    f_four_s;
	logic [SampleW-1:0] r_root;
	logic        r_done;
	vgm_result_t out_q;
	logic        out_valid_q;

	assign en          = !out_valid_q || out_ch.ready;
	assign in_ch.ready = en;

	vgm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk, .arst_n, .en, .restart,
		.width_reg(width_q), .height_reg(height_q), .wide(wide_q),
		.in_valid(in_ch.valid), .in_sample(in_ch.data),
		.out_valid(f_valid), .out_four_s(f_four_s), .out_done(f_done)
	);

	vgm_sqrt_pipe #(.TagW(1)) u_sqrt (
		.clk, .arst_n, .en,
		.in_valid(f_valid), .in_four_s(f_four_s), .in_tag(f_done),
		.out_valid(r_valid), .out_root(r_root), .out_tag(r_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= r_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_q.gradient   <= r_root;
			out_q.slice_done <= r_done;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
endmodule

// ===== rtl/vgm_checker.sv =====
// Checker: port-level properties of the gradient block, bound to the top level
`timescale 1ns / 1ps
module vgm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [16:0] out_data
);
	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	// input is ready whenever output is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	// input never blocked when output is being taken
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");
endmodule

bind volume_gradient_magnitude vgm_checker u_vgm_checker (
	.clk(clk), .arst_n(arst_n),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_data(out_ch.data)
);
